/* rtl/afc_pkg.sv */
`timescale 1ns / 1ps

package afc_pkg;

  localparam int NUM_ENTITIES = 1024;
  localparam int CORDIC_STEPS = 16;

  localparam int IDX_W = $clog2(NUM_ENTITIES);
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W = 5;

  localparam int MOD_W = 33;
  localparam int ANG_W = 27;
  localparam int CORD_W = 34;
  localparam int ACC_W = 50;

  localparam logic [MOD_W-1:0] DEG360_M = 33'd23592960;
  localparam logic [MOD_W-1:0] MOD_OFFSET = 33'd2170552320;
  localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG90 = 27'sd5898240;
  localparam logic signed [CORD_W-1:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } matrix_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] sin;
    logic signed [31:0] cos;
  } trig_t;

  function automatic logic signed [31:0] atan_deg(input logic [ATAN_IDX_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd2949120;
      5'd1: v = 32'sd1740967;
      5'd2: v = 32'sd919879;
      5'd3: v = 32'sd466945;
      5'd4: v = 32'sd234379;
      5'd5: v = 32'sd117304;
      5'd6: v = 32'sd58666;
      5'd7: v = 32'sd29335;
      5'd8: v = 32'sd14668;
      5'd9: v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff})) begin
      r = 32'sh7fffffff;
    end else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h80000000})) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/affine_transform_compose.sv */
`timescale 1ns / 1ps

// Composes 2D affine transforms in signed Q16.16. After reset all 1024 entries of the
// matrix store are cleared, during which busy is high. An item is taken when start is high
// and busy is low; busy then stays high until the result is produced. Each item goes
// through eight range-reduction steps and sixteen CORDIC steps in the angle unit, then four
// products without a parent or sixteen with one on one shared 32 by 32 multiplier. The
// result is shown for exactly one cycle with done high and cannot be held off, and busy is
// already low then.

module affine_transform_compose import afc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         entity_index,
  input  logic [9:0]         parent_index,
  input  logic               has_parent,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] rotation_deg,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  output logic               done,
  output logic signed [31:0] world_a,
  output logic signed [31:0] world_b,
  output logic signed [31:0] world_c,
  output logic signed [31:0] world_d,
  output logic signed [31:0] world_tx,
  output logic signed [31:0] world_ty
);

  typedef enum logic [1:0] {S_IDLE, S_ANGLE, S_MUL, S_DONE} state_t;

  localparam logic [4:0] MUL_LAST_LOCAL = 5'd3;
  localparam logic [4:0] MUL_LAST_WORLD = 5'd15;

  state_t state;
  logic accept;
  logic store_ready;
  trig_t trig;
  matrix_t par, wr_data;

  logic [IDX_W-1:0] ent;
  logic has_par;
  logic signed [31:0] px, py, sx, sy, s, c;
  logic signed [31:0] la, lb, lc, ld;
  logic signed [31:0] wa, wb, wc, wd, wtx, wty;
  logic [4:0] m, last;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [31:0] op_a, op_b, pt;
  logic signed [63:0] mul_full, rnd;
  logic signed [ACC_W-1:0] rq, total;
  logic [4:0] j;

  assign busy = (state != S_IDLE) || !store_ready;
  assign accept = start && !busy;
  assign last = has_par ? MUL_LAST_WORLD : MUL_LAST_LOCAL;
  assign j = m - 1'b1;

  afc_angle u_angle (
    .clk  (clk),
    .rst  (rst),
    .go   (accept),
    .deg  (rotation_deg),
    .trig (trig)
  );

  afc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (parent_index[IDX_W-1:0]),
    .rd_data (par),
    .wr_en   (state == S_DONE),
    .wr_addr (ent),
    .wr_data (wr_data),
    .ready   (store_ready)
  );

  always_comb begin
    case (m)
      5'd0: begin op_a = c; op_b = sx; end
      5'd1: begin op_a = s; op_b = sy; end
      5'd2: begin op_a = s; op_b = sx; end
      5'd3: begin op_a = c; op_b = sy; end
      5'd4: begin op_a = par.a; op_b = la; end
      5'd5: begin op_a = par.b; op_b = lc; end
      5'd6: begin op_a = par.a; op_b = lb; end
      5'd7: begin op_a = par.b; op_b = ld; end
      5'd8: begin op_a = par.c; op_b = la; end
      5'd9: begin op_a = par.d; op_b = lc; end
      5'd10: begin op_a = par.c; op_b = lb; end
      5'd11: begin op_a = par.d; op_b = ld; end
      5'd12: begin op_a = par.a; op_b = px; end
      5'd13: begin op_a = par.b; op_b = py; end
      5'd14: begin op_a = par.c; op_b = px; end
      5'd15: begin op_a = par.d; op_b = py; end
      default: begin op_a = '0; op_b = '0; end
    endcase
    mul_full = op_a * op_b;
    rnd = prod + 64'sd32768;
    rq = {{(ACC_W-48){rnd[63]}}, rnd[63:16]};
    case (j)
      5'd13: pt = par.tx;
      5'd15: pt = par.ty;
      default: pt = '0;
    endcase
    total = acc + rq + {{(ACC_W-32){pt[31]}}, pt};
    if (has_par) begin
      wr_data = '{a: wa, b: wb, c: wc, d: wd, tx: wtx, ty: wty};
    end else begin
      wr_data = '{a: la, b: lb, c: lc, d: ld, tx: px, ty: py};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            ent <= entity_index[IDX_W-1:0];
            has_par <= has_parent;
            px <= pos_x;
            py <= pos_y;
            sx <= scale_x;
            sy <= scale_y;
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          if (trig.done) begin
            s <= trig.sin;
            c <= trig.cos;
            m <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= mul_full;
          if (m != 5'd0) begin
            case (j)
              5'd0: la <= sat32(rq);
              5'd1: lb <= sat32(-rq);
              5'd2: lc <= sat32(rq);
              5'd3: ld <= sat32(rq);
              5'd5: wa <= sat32(total);
              5'd7: wb <= sat32(total);
              5'd9: wc <= sat32(total);
              5'd11: wd <= sat32(total);
              5'd13: wtx <= sat32(total);
              5'd15: wty <= sat32(total);
              default: acc <= rq;
            endcase
          end
          if (m == last + 1'b1) begin
            state <= S_DONE;
          end else begin
            m <= m + 1'b1;
          end
        end
        S_DONE: begin
          world_a <= wr_data.a;
          world_b <= wr_data.b;
          world_c <= wr_data.c;
          world_d <= wr_data.d;
          world_tx <= wr_data.tx;
          world_ty <= wr_data.ty;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/afc_store.sv */
`timescale 1ns / 1ps

module afc_store import afc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output matrix_t          rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  matrix_t          wr_data,
  output logic             ready
);

  matrix_t mem [NUM_ENTITIES];
  logic clearing;
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == IDX_W'(NUM_ENTITIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

/* rtl/afc_angle.sv */
`timescale 1ns / 1ps

module afc_angle import afc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] deg,
  output trig_t              trig
);

  typedef enum logic [2:0] {A_IDLE, A_MOD, A_FOLD, A_ROT, A_ROUND} astate_t;

  astate_t state;
  logic [MOD_W-1:0] v;
  logic [2:0] k;
  logic [STEP_W-1:0] i;
  logic signed [CORD_W-1:0] x, y;
  logic signed [31:0] z;
  logic neg;

  logic [MOD_W-1:0] cmp;
  logic signed [MOD_W:0] deg_off;
  logic signed [ANG_W-1:0] r0, r1, r2;
  logic neg_next;
  logic signed [CORD_W-1:0] dx, dy, xr, yr;
  logic signed [31:0] at;

  always_comb begin
    deg_off = {{2{deg[31]}}, deg} + $signed({1'b0, MOD_OFFSET});
    cmp = DEG360_M << k;
    r0 = $signed({{(ANG_W-25){1'b0}}, v[24:0]});
    r1 = (r0 > DEG180) ? r0 - DEG360 : r0;
    neg_next = 1'b0;
    r2 = r1;
    if (r1 > DEG90) begin
      r2 = r1 - DEG180;
      neg_next = 1'b1;
    end else if (r1 < -DEG90) begin
      r2 = r1 + DEG180;
      neg_next = 1'b1;
    end
    dx = y >>> i;
    dy = x >>> i;
    at = atan_deg(ATAN_IDX_W'(i));
    xr = (x + 34'sd8192) >>> 14;
    yr = (y + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      trig.done <= 1'b0;
    end else begin
      trig.done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (go) begin
            v <= deg_off[MOD_W-1:0];
            k <= 3'd7;
            state <= A_MOD;
          end
        end
        A_MOD: begin
          if (v >= cmp) begin
            v <= v - cmp;
          end
          if (k == 3'd0) begin
            state <= A_FOLD;
          end else begin
            k <= k - 1'b1;
          end
        end
        A_FOLD: begin
          z <= 32'(r2);
          neg <= neg_next;
          x <= GAIN_Q30;
          y <= '0;
          i <= '0;
          state <= A_ROT;
        end
        A_ROT: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          if (i == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= A_ROUND;
          end else begin
            i <= i + 1'b1;
          end
        end
        A_ROUND: begin
          trig.cos <= neg ? -xr[31:0] : xr[31:0];
          trig.sin <= neg ? -yr[31:0] : yr[31:0];
          trig.done <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* rtl/afc_checker.sv */
`timescale 1ns / 1ps

module afc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // The clearing pass keeps the block busy straight after reset.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an item was taken");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done ##1 !done)
    else $error("result too soon after an item was taken");

endmodule

bind affine_transform_compose afc_checker u_afc_checker (.*);
